// ===== hw/rtl/greedy_diversity_reranker_top_defines.svh =====
// Assertion macros shared by the reranker RTL.
`ifndef GREEDY_DIVERSITY_RERANKER_TOP_DEFINES_SVH
`define GREEDY_DIVERSITY_RERANKER_TOP_DEFINES_SVH

// Implication or plain property checked on every clock, off during reset.
`define GDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true.
`define GDR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/gdr_pkg.sv =====
// ----------------------------------------------------------------------------
// gdr_pkg
// Constants and widths of the greedy diversity reranker.
// ----------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;
  localparam int unsigned MaxItems  = 512;
  localparam int unsigned MaxPicks  = 50;
  localparam int unsigned IdxW      = $clog2(MaxItems);
  localparam int unsigned CntW      = $clog2(MaxItems + 1);
  localparam int unsigned RankW     = 6;
  localparam int unsigned SumW      = 22;
  localparam int unsigned KW        = 9;
  localparam int unsigned CfgW      = 9;
  localparam int unsigned IdW       = 32;
  localparam int unsigned ClW       = 8;
  localparam int unsigned RelW      = 16;
  localparam int unsigned Slots     = 256;
  localparam logic [RelW-1:0] RelFloor = 16'd32;
endpackage

`default_nettype wire

// ===== hw/rtl/gdr_if.sv =====
// ----------------------------------------------------------------------------
// gdr_item_if / gdr_result_if
// Valid/ready channels carrying input items and ranked results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdr_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] image_id;
  logic [7:0]  cluster_id;
  logic [15:0] relevance;
  logic        last_item;
  modport source (output valid, image_id, cluster_id, relevance, last_item, input ready);
  modport sink   (input valid, image_id, cluster_id, relevance, last_item, output ready);
endinterface

interface gdr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] picked_image;
  logic [5:0]  rank;
  logic        final_pick;
  modport source (output valid, picked_image, rank, final_pick, input ready);
  modport sink   (input valid, picked_image, rank, final_pick, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/greedy_diversity_reranker_top.sv =====
// Items load one per cycle into on-chip memories while item_i.ready is high.
// The item with last_item set starts a ranked run, and item_i.ready stays low
// until the run's final result is in the output register. Rank 0 comes from a
// scan of the n stored items, and each further pick from a scan that scores the
// u items not yet taken on one shared 32x32 multiplier that evaluates the
// F-score cross products of a candidate in six steps. Results wait in an
// output register; the sequencer pauses while it is full.
`default_nettype none

`include "greedy_diversity_reranker_top_defines.svh"

module greedy_diversity_reranker_top
  import gdr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  gdr_item_if.sink             item_i,
  gdr_result_if.source         result_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MX_RD, ST_MX_EV, ST_TK_RD, ST_TK_EV,
    ST_GR_RD, ST_GR_EV, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5
  } state_e;

  logic [IdW-1:0]  id_mem  [MaxItems];
  logic [ClW-1:0]  cl_mem  [MaxItems];
  logic [RelW-1:0] rel_mem [MaxItems];
  logic            tk_mem  [MaxItems];

  state_e          state_q;
  logic [CntW-1:0] cnt_q, idx_q, best_q, ff_q;
  logic            best_vld_q, ff_vld_q;
  logic [RankW-1:0] chosen_q;
  logic [SumW-1:0] sum_q, s_q;
  logic [KW-1:0]   kcov_q, kc_q;
  logic [Slots-1:0] cov_q;
  logic [CfgW-1:0] ccount_q;
  logic [RelW-1:0] best_rel_q;
  logic [31:0]     num_q, den_q, d1_q, bnum_q, bden_q;
  logic [63:0]     lhs_q, rhs_q;

  logic            out_valid_q, out_fin_q;
  logic [IdW-1:0]  out_id_q;
  logic [RankW-1:0] out_rank_q;

  logic [IdxW-1:0] rd_addr;
  logic [IdW-1:0]  rd_id;
  logic [ClW-1:0]  rd_cl;
  logic [RelW-1:0] rd_rel;
  logic            rd_tk;

  logic            load;
  logic            tk_we, tk_wd;
  logic [IdxW-1:0] tk_wa;
  logic            last_idx, adds;
  logic [SumW-1:0] s_new;
  logic [KW-1:0]   kc_new;
  logic [RankW-1:0] chosen_nx;
  logic            fin;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;

  assign item_i.ready      = (state_q == ST_IDLE);
  assign load              = item_i.valid && item_i.ready;
  assign result_o.valid    = out_valid_q;
  assign result_o.picked_image = out_id_q;
  assign result_o.rank     = out_rank_q;
  assign result_o.final_pick = out_fin_q;

  always_comb begin
    case (state_q)
      ST_MX_RD, ST_GR_RD: rd_addr = idx_q[IdxW-1:0];
      default:            rd_addr = best_q[IdxW-1:0];
    endcase
  end

  always_comb begin
    tk_we = 1'b0;
    tk_wd = 1'b0;
    tk_wa = cnt_q[IdxW-1:0];
    if (load && cnt_q < CntW'(MaxItems)) begin
      tk_we = 1'b1;
    end else if (state_q == ST_TK_EV) begin
      tk_we = 1'b1;
      tk_wd = 1'b1;
      tk_wa = best_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && cnt_q < CntW'(MaxItems)) begin
      id_mem[cnt_q[IdxW-1:0]]  <= item_i.image_id;
      cl_mem[cnt_q[IdxW-1:0]]  <= item_i.cluster_id;
      rel_mem[cnt_q[IdxW-1:0]] <= item_i.relevance;
    end
    if (tk_we) begin
      tk_mem[tk_wa] <= tk_wd;
    end
    rd_id  <= id_mem[rd_addr];
    rd_cl  <= cl_mem[rd_addr];
    rd_rel <= rel_mem[rd_addr];
    rd_tk  <= tk_mem[rd_addr];
  end

  assign last_idx  = (idx_q + CntW'(1) == cnt_q);
  assign adds      = (rd_rel > RelFloor) && !cov_q[rd_cl];
  assign s_new     = sum_q + SumW'(rd_rel);
  assign kc_new    = kcov_q + KW'(adds);
  assign chosen_nx = chosen_q + RankW'(1);
  assign fin       = (chosen_q == RankW'(MaxPicks)) || (CntW'(chosen_nx) == cnt_q);

  always_comb begin
    case (state_q)
      ST_M0:   begin mul_a = 32'(s_q);    mul_b = 32'(kc_q);      end
      ST_M1:   begin mul_a = 32'(s_q);    mul_b = 32'(ccount_q);  end
      ST_M2:   begin mul_a = 32'(kc_q);   mul_b = 32'(chosen_nx); end
      ST_M3:   begin mul_a = num_q;       mul_b = bden_q;         end
      default: begin mul_a = bnum_q;      mul_b = den_q;          end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      ff_q        <= '0;
      best_vld_q  <= 1'b0;
      ff_vld_q    <= 1'b0;
      chosen_q    <= '0;
      sum_q       <= '0;
      kcov_q      <= '0;
      cov_q       <= '0;
      ccount_q    <= CfgW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ccount_q <= cfg_data_i;
      end
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (load) begin
            if (cnt_q < CntW'(MaxItems)) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            if (item_i.last_item) begin
              idx_q   <= '0;
              state_q <= ST_MX_RD;
            end
          end
        end
        ST_MX_RD: state_q <= ST_MX_EV;
        ST_MX_EV: begin
          if (idx_q == '0 || rd_rel > best_rel_q) begin
            best_q     <= idx_q;
            best_rel_q <= rd_rel;
          end
          idx_q   <= idx_q + CntW'(1);
          state_q <= last_idx ? ST_TK_RD : ST_MX_RD;
        end
        ST_TK_RD: begin
          if (!out_valid_q) begin
            state_q <= ST_TK_EV;
          end
        end
        ST_TK_EV: begin
          out_valid_q <= 1'b1;
          out_id_q    <= rd_id;
          out_rank_q  <= chosen_q;
          out_fin_q   <= fin;
          if (fin) begin
            cnt_q    <= '0;
            cov_q    <= '0;
            sum_q    <= '0;
            kcov_q   <= '0;
            chosen_q <= '0;
            state_q  <= ST_IDLE;
          end else begin
            sum_q <= s_new;
            if (adds) begin
              cov_q[rd_cl] <= 1'b1;
              kcov_q       <= kcov_q + KW'(1);
            end
            chosen_q   <= chosen_nx;
            idx_q      <= '0;
            best_vld_q <= 1'b0;
            ff_vld_q   <= 1'b0;
            state_q    <= ST_GR_RD;
          end
        end
        ST_GR_RD: state_q <= ST_GR_EV;
        ST_GR_EV: begin
          if (!rd_tk && !ff_vld_q) begin
            ff_q     <= idx_q;
            ff_vld_q <= 1'b1;
          end
          if (!rd_tk && ccount_q != '0 && s_new != '0) begin
            s_q     <= s_new;
            kc_q    <= kc_new;
            state_q <= ST_M0;
          end else begin
            idx_q <= idx_q + CntW'(1);
            if (last_idx) begin
              if (!best_vld_q) begin
                best_q <= (!rd_tk && !ff_vld_q) ? idx_q : ff_q;
              end
              state_q <= ST_TK_RD;
            end else begin
              state_q <= ST_GR_RD;
            end
          end
        end
        ST_M0: begin
          num_q   <= {prod[30:0], 1'b0};
          state_q <= ST_M1;
        end
        ST_M1: begin
          d1_q    <= prod[31:0];
          state_q <= ST_M2;
        end
        ST_M2: begin
          den_q   <= d1_q + {prod[16:0], 15'd0};
          state_q <= ST_M3;
        end
        ST_M3: begin
          lhs_q   <= prod;
          state_q <= ST_M4;
        end
        ST_M4: begin
          rhs_q   <= prod;
          state_q <= ST_M5;
        end
        ST_M5: begin
          if (!best_vld_q || lhs_q > rhs_q) begin
            best_q     <= idx_q;
            best_vld_q <= 1'b1;
            bnum_q     <= num_q;
            bden_q     <= den_q;
          end
          idx_q <= idx_q + CntW'(1);
          if (last_idx) begin
            state_q <= ST_TK_RD;
          end else begin
            state_q <= ST_GR_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `GDR_NEVER(a_kcov_range, kcov_q > KW'(Slots), "covered count beyond cluster slots")
  `GDR_NEVER(a_chosen_le_cnt, state_q != ST_IDLE && CntW'(chosen_q) > cnt_q, "more picks than items")
  `GDR_ASSERT(a_run_clears, (state_q == ST_TK_EV && fin) |=> (cnt_q == '0 && kcov_q == '0), "run state not cleared")

endmodule

`default_nettype wire

// ===== tb/greedy_diversity_reranker_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy diversity reranker testbench
// Loads image sets through the item channel and predicts the reranked order
// with a bit-exact model of the greedy F-score picks. Covers cluster counts
// of zero, one and the largest value, and all-zero relevance. Both channels
// stall at random.
// ----------------------------------------------------------------------------
module greedy_diversity_reranker_top_test;
  import gdr_pkg::*;

  localparam int unsigned StallLimit = 100000;

  typedef struct packed {
    logic [IdW-1:0]   picked_image;
    logic [RankW-1:0] rank;
    logic             final_pick;
  } rank_entry_t;

  class rank_scoreboard;
    logic [IdW-1:0]  ids[MaxItems];
    logic [ClW-1:0]  clusters[MaxItems];
    logic [RelW-1:0] rels[MaxItems];
    bit              taken[MaxItems];
    bit              covered[Slots];
    int unsigned     loaded, rel_sum, cov_count, chosen;
    logic [CfgW-1:0] cluster_count;
    rank_entry_t     ranked_q[$];
    int unsigned     errors;

    function void clear_set();
      foreach (taken[i]) taken[i] = 0;
      foreach (covered[i]) covered[i] = 0;
      loaded = 0;
      rel_sum = 0;
      cov_count = 0;
    endfunction

    function bit new_cluster(int unsigned idx);
      return rels[idx] > RelFloor && !covered[clusters[idx]];
    endfunction

    function void take(int unsigned idx, bit fin);
      rank_entry_t e;
      taken[idx] = 1;
      rel_sum += rels[idx];
      if (new_cluster(idx)) begin
        covered[clusters[idx]] = 1;
        cov_count++;
      end
      e.picked_image = ids[idx];
      e.rank = RankW'(chosen);
      e.final_pick = fin;
      ranked_q = {ranked_q, e};
      chosen++;
    endfunction

    function void note_item(logic [IdW-1:0] id, logic [ClW-1:0] cl, logic [RelW-1:0] rel,
                            bit last);
      int unsigned best, free_idx, n;
      longint unsigned s, kc, num, den, bnum, bden;
      if (loaded < MaxItems) begin
        ids[loaded] = id;
        clusters[loaded] = cl;
        rels[loaded] = rel;
        loaded++;
      end
      if (!last) return;
      n = loaded;
      chosen = 0;
      best = 0;
      for (int unsigned i = 1; i < n; i++)
        if (rels[i] > rels[best]) best = i;
      take(best, n == 1);
      for (int p = 0; p < MaxPicks && chosen < n; p++) begin
        free_idx = n;
        best = n;
        bnum = 0;
        bden = 1;
        for (int unsigned i = 0; i < n; i++) begin
          if (taken[i]) continue;
          if (free_idx == n) free_idx = i;
          if (cluster_count == 0) continue;
          s = rel_sum + rels[i];
          if (s == 0) continue;
          kc = cov_count + new_cluster(i);
          num = 2 * s * kc;
          den = s * cluster_count + kc * (chosen + 1) * 32768;
          if (best == n || num * bden > bnum * den) begin
            best = i;
            bnum = num;
            bden = den;
          end
        end
        if (best == n) best = free_idx;
        take(best, p == MaxPicks - 1 || chosen + 1 == n);
      end
      clear_set();
    endfunction

    function void check_result(logic [IdW-1:0] id, logic [RankW-1:0] rk, logic fin);
      rank_entry_t e;
      if (ranked_q.size() == 0) begin
        $error("unexpected result image %0d rank %0d", id, rk);
        errors++;
        return;
      end
      e = ranked_q.pop_front();
      if (id !== e.picked_image) begin
        $error("picked_image exp %0d got %0d", e.picked_image, id);
        errors++;
      end
      if (rk !== e.rank) begin
        $error("rank exp %0d got %0d", e.rank, rk);
        errors++;
      end
      if (fin !== e.final_pick) begin
        $error("final_pick exp %0d got %0d", e.final_pick, fin);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  bit calm = 0;
  int unsigned stall_cycles = 0;
  rank_scoreboard sb = new();

  gdr_item_if item_ch();
  gdr_result_if result_ch();

  greedy_diversity_reranker_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .item_i(item_ch.sink), .result_o(result_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.image_id = '0;
    item_ch.cluster_id = '0;
    item_ch.relevance = '0;
    item_ch.last_item = 1'b0;
    result_ch.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    result_ch.ready <= calm || ($urandom_range(99) >= 18);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.picked_image, result_ch.rank, result_ch.final_pick);
      if ((result_ch.valid && result_ch.ready) || (item_ch.valid && item_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic [IdW-1:0] id, logic [ClW-1:0] cl, logic [RelW-1:0] rel,
                           bit last);
    if (!calm && $urandom_range(99) < 18) begin
      item_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 18);
    end
    item_ch.valid <= 1'b1;
    item_ch.image_id <= id;
    item_ch.cluster_id <= cl;
    item_ch.relevance <= rel;
    item_ch.last_item <= last;
    do @(posedge clk_i); while (!item_ch.ready);
    sb.note_item(id, cl, rel, last);
    @(negedge clk_i);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.ranked_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cluster_count(logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    sb.cluster_count = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [RelW-1:0] rand_rel();
    case ($urandom_range(7))
      0: return '0;
      1: return RelW'($urandom_range(32));
      2: return 16'd33;
      3: return 16'd32768;
      4: return RelW'($urandom_range(65535));
      default: return RelW'($urandom_range(32768));
    endcase
  endfunction

  task automatic random_set(int n, int ncl);
    for (int i = 0; i < n; i++)
      send_item($urandom, ClW'($urandom_range(ncl - 1)), rand_rel(), i == n - 1);
    drain();
  endtask

  initial begin
    int sent;
    sb.cluster_count = CfgW'(1);
    sb.clear_set();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // one item alone, then all-zero relevance
    send_item(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1);
    drain();
    send_item(32'd0, 8'd0, 16'd0, 1'b0);
    send_item(32'd1, 8'd0, 16'd0, 1'b0);
    send_item(32'd2, 8'd1, 16'd0, 1'b1);
    drain();
    write_cluster_count(9'd0);
    send_item(32'd10, 8'd3, 16'd32768, 1'b0);
    send_item(32'd11, 8'd4, 16'd100, 1'b0);
    send_item(32'd12, 8'd5, 16'd32768, 1'b1);
    drain();
    write_cluster_count(9'd511);
    send_item(32'hA5A5_5A5A, 8'h00, 16'd32, 1'b0);
    send_item(32'h5A5A_A5A5, 8'hFF, 16'd33, 1'b0);
    send_item(32'h1234_5678, 8'h80, 16'd65535, 1'b0);
    send_item(32'h8765_4321, 8'h80, 16'd32768, 1'b0);
    send_item(32'h0F0F_0F0F, 8'h7F, 16'h5555, 1'b0);
    send_item(32'hF0F0_F0F0, 8'h01, 16'hAAAA, 1'b1);
    drain();
    write_cluster_count(9'd256);
    calm = 1;
    random_set(60, 256);
    calm = 0;

    sent = 72;
    while (sent < 255) begin
      int n;
      case ($urandom_range(3))
        0: write_cluster_count(CfgW'($urandom_range(1, 8)));
        1: write_cluster_count(CfgW'($urandom_range(511)));
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      random_set(n, $urandom_range(1, 256));
      sent += n;
    end

    write_cluster_count(9'd1);
    random_set(5, 3);

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
